FILE: hdl/tapcc_pkg.sv
// Package for the two-arm positioner collision check.
// Holds widths, register indexes, CORDIC constants and the arctangent table.
`default_nettype none
package tapcc_pkg;
    localparam int ANGLE_BITS_DEF    = 16;
    localparam int COORD_BITS_DEF    = 24;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int REG_BITS          = 16;
    localparam int CFG_IDX_BITS      = 2;
    localparam int ATAN_LEN          = 24;
    localparam logic [31:0] KINV_Q31 = 32'd1304065748;

    localparam logic [CFG_IDX_BITS-1:0] REG_FIRST_ARM  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SECOND_ARM = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS_A   = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS_B   = 2'd3;

    // atan(2^-i) in units of 2^-32 turn; zero past the table
    function automatic logic [31:0] atan_turns(input int i);
        logic [31:0] t;
        case (i)
            0: t = 32'd536870912;  1: t = 32'd316933406;  2: t = 32'd167458907;
            3: t = 32'd85004756;   4: t = 32'd42667331;   5: t = 32'd21354465;
            6: t = 32'd10679838;   7: t = 32'd5340245;    8: t = 32'd2670163;
            9: t = 32'd1335087;    10: t = 32'd667544;    11: t = 32'd333772;
            12: t = 32'd166886;    13: t = 32'd83443;     14: t = 32'd41722;
            15: t = 32'd20861;     16: t = 32'd10430;     17: t = 32'd5215;
            18: t = 32'd2608;      19: t = 32'd1304;      20: t = 32'd652;
            21: t = 32'd326;       22: t = 32'd163;       23: t = 32'd81;
            default: t = 32'd0;
        endcase
        return t;
    endfunction
endpackage
`default_nettype wire

FILE: hdl/tapcc_stream_if.sv
// Valid/ready stream interface with a parameterized payload type.
// Depends on nothing.
`default_nettype none
interface tapcc_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/tapcc_rotator.sv
// Pipelined CORDIC rotator: turns (len, angle) into a rounded vector.
// Depends on tapcc_pkg. One stage per CORDIC step plus an input and output stage.
`default_nettype none
module tapcc_rotator
    import tapcc_pkg::*;
#(
    parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  en,
    input  wire logic [REG_BITS-1:0]   len,
    input  wire logic [ANGLE_BITS-1:0] angle,
    output logic signed [REG_BITS+1:0] dx,
    output logic signed [REG_BITS+1:0] dy
);
    // internal precision: len * Kinv >> 23 has up to 24 bits, plus growth
    localparam int W = REG_BITS + 14;

    logic signed [W-1:0] x_reg [CORDIC_STAGES+1];
    logic signed [W-1:0] y_reg [CORDIC_STAGES+1];
    logic signed [32:0]  z_reg [CORDIC_STAGES+1];
    logic                flip_reg [CORDIC_STAGES+1];
    logic [31:0]         a32;
    logic                flip_in;
    logic [31:0]         a_adj;
    logic [47:0]         prod;
    logic signed [W-1:0] xr, yr;

    // entry: quadrant fold and gain-compensated start vector
    always_comb
    begin
        a32     = {angle, {(32-ANGLE_BITS){1'b0}}};
        flip_in = a32[31] ^ a32[30];
        a_adj   = flip_in ? (a32 + 32'h8000_0000) : a32;
        prod    = {32'd0, len} * {16'd0, KINV_Q31};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= W'($signed({1'b0, prod[47:23]}));
            y_reg[0]    <= '0;
            z_reg[0]    <= {a_adj[31], a_adj};
            flip_reg[0] <= flip_in;
        end
    end

    // rotation steps
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_step
        localparam logic [31:0] T = atan_turns(i);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][32])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - $signed({1'b0, T});
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + $signed({1'b0, T});
                end
                flip_reg[i+1] <= flip_reg[i];
            end
        end
    end

    // rounding and unfold
    always_comb
    begin
        xr = (x_reg[CORDIC_STAGES] + W'(128)) >>> 8;
        yr = (y_reg[CORDIC_STAGES] + W'(128)) >>> 8;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx <= flip_reg[CORDIC_STAGES] ? -xr[REG_BITS+1:0] : xr[REG_BITS+1:0];
            dy <= flip_reg[CORDIC_STAGES] ? -yr[REG_BITS+1:0] : yr[REG_BITS+1:0];
        end
    end
endmodule
`default_nettype wire

FILE: hdl/two_arm_positioner_collision_check.sv
// Top level of the two-arm positioner pair collision check.
// Depends on tapcc_pkg, tapcc_stream_if and tapcc_rotator.
//
//  channel | dir | content
//  in_ch   | in  | centers and joint angles of positioners A and B
//  out_ch  | out | collide and the three overlap flags
//  cfg     | in  | arm lengths and keep-out radii, write only
//
// One item per cycle while the output is not stalled. Pipeline stages: input stage,
// CORDIC (stages + 2), elbow, tip, difference, square, sum/compare.
// Reset clears valid bits and loads register defaults; payload is not reset.
// The whole pipe advances only when the output stage is free or taken.
`default_nettype none
module two_arm_positioner_collision_check
    import tapcc_pkg::*;
#(
    parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
    parameter int COORD_BITS    = COORD_BITS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    tapcc_stream_if.sink                 in_ch,
    tapcc_stream_if.source               out_ch,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [REG_BITS-1:0]     cfg_data
);
    localparam int PW    = COORD_BITS + 2;     // point width
    localparam int DW    = COORD_BITS + 3;     // difference width
    localparam int LAT   = CORDIC_STAGES + 8;
    localparam int CD    = CORDIC_STAGES + 2;  // rotator depth

    // configuration
    logic [REG_BITS-1:0] len1_reg, len2_reg, rad_a_reg, rad_b_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len1_reg  <= 16'd12288;
            len2_reg  <= 16'd12288;
            rad_a_reg <= 16'd4096;
            rad_b_reg <= 16'd4096;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FIRST_ARM:  len1_reg  <= cfg_data;
                REG_SECOND_ARM: len2_reg  <= cfg_data;
                REG_RADIUS_A:   rad_a_reg <= cfg_data;
                REG_RADIUS_B:   rad_b_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline control
    logic [LAT-1:0] vld_reg;
    logic           en;
    assign en          = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = en;
    assign out_ch.valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], in_ch.valid};
    end

    // input stage
    logic [ANGLE_BITS-1:0]        ang_reg [4];
    logic signed [COORD_BITS-1:0] c_reg [4];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg[0]   <= in_ch.data.center_x_a;
            c_reg[1]   <= in_ch.data.center_y_a;
            c_reg[2]   <= in_ch.data.center_x_b;
            c_reg[3]   <= in_ch.data.center_y_b;
            ang_reg[0] <= in_ch.data.first_angle_a;
            ang_reg[1] <= in_ch.data.second_angle_a;
            ang_reg[2] <= in_ch.data.first_angle_b;
            ang_reg[3] <= in_ch.data.second_angle_b;
        end
    end

    // four rotators: arm 1 / arm 2 of A and B
    logic signed [REG_BITS+1:0] rdx [4];
    logic signed [REG_BITS+1:0] rdy [4];
    for (genvar k = 0; k < 4; k++) begin : g_rot
        tapcc_rotator #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_rot (
            .clk   (clk),
            .en    (en),
            .len   ((k % 2 == 0) ? len1_reg : len2_reg),
            .angle (ang_reg[k]),
            .dx    (rdx[k]),
            .dy    (rdy[k])
        );
    end

    // centers delayed alongside the rotators
    logic signed [COORD_BITS-1:0] cd_reg [CD][4];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cd_reg[0] <= c_reg;
            for (int s = 1; s < CD; s++)
                cd_reg[s] <= cd_reg[s-1];
        end
    end

    // elbow stage
    logic signed [PW-1:0] ex_reg [2], ey_reg [2];
    logic signed [REG_BITS+1:0] t2x_reg [2], t2y_reg [2];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int p = 0; p < 2; p++)
            begin
                ex_reg[p]  <= PW'(cd_reg[CD-1][2*p])   + PW'(rdx[2*p]);
                ey_reg[p]  <= PW'(cd_reg[CD-1][2*p+1]) + PW'(rdy[2*p]);
                t2x_reg[p] <= rdx[2*p+1];
                t2y_reg[p] <= rdy[2*p+1];
            end
        end
    end

    // tip stage
    logic signed [PW-1:0] e2x_reg [2], e2y_reg [2], tx_reg [2], ty_reg [2];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int p = 0; p < 2; p++)
            begin
                e2x_reg[p] <= ex_reg[p];
                e2y_reg[p] <= ey_reg[p];
                tx_reg[p]  <= ex_reg[p] + PW'(t2x_reg[p]);
                ty_reg[p]  <= ey_reg[p] + PW'(t2y_reg[p]);
            end
        end
    end

    // difference stage: abs distance per test, far flag
    // test 0: elbow A vs tip B, 1: tip A vs elbow B, 2: tip A vs tip B
    logic signed [DW-1:0] ddx [3], ddy [3];
    logic [DW-1:0]        adx [3], ady [3];
    logic [REG_BITS:0]    rs;
    logic [REG_BITS:0]    ax_reg [3], ay_reg [3];
    logic                 far_reg [3];
    logic [REG_BITS:0]    rs_reg;
    always_comb
    begin
        rs = {1'b0, rad_a_reg} + {1'b0, rad_b_reg};
        ddx[0] = DW'(e2x_reg[0]) - DW'(tx_reg[1]);
        ddy[0] = DW'(e2y_reg[0]) - DW'(ty_reg[1]);
        ddx[1] = DW'(tx_reg[0])  - DW'(e2x_reg[1]);
        ddy[1] = DW'(ty_reg[0])  - DW'(e2y_reg[1]);
        ddx[2] = DW'(tx_reg[0])  - DW'(tx_reg[1]);
        ddy[2] = DW'(ty_reg[0])  - DW'(ty_reg[1]);
        for (int t = 0; t < 3; t++)
        begin
            adx[t] = ddx[t][DW-1] ? DW'(-ddx[t]) : DW'(ddx[t]);
            ady[t] = ddy[t][DW-1] ? DW'(-ddy[t]) : DW'(ddy[t]);
        end
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rs_reg <= rs;
            for (int t = 0; t < 3; t++)
            begin
                ax_reg[t]  <= adx[t][REG_BITS:0];
                ay_reg[t]  <= ady[t][REG_BITS:0];
                far_reg[t] <= (adx[t] > DW'(rs)) || (ady[t] > DW'(rs));
            end
        end
    end

    // square stage
    logic [2*REG_BITS+1:0] sx_reg [3], sy_reg [3], rr_reg;
    logic                  far2_reg [3];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rr_reg <= rs_reg * rs_reg;
            for (int t = 0; t < 3; t++)
            begin
                sx_reg[t]   <= ax_reg[t] * ax_reg[t];
                sy_reg[t]   <= ay_reg[t] * ay_reg[t];
                far2_reg[t] <= far_reg[t];
            end
        end
    end

    // compare stage into output register
    logic [2:0] hit_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int t = 0; t < 3; t++)
                hit_reg[t] <= !far2_reg[t] &&
                    ({1'b0, rr_reg} > ({1'b0, sx_reg[t]} + {1'b0, sy_reg[t]}));
        end
    end

    assign out_ch.data.collide            = |hit_reg;
    assign out_ch.data.elbow_a_hits_tip_b = hit_reg[0];
    assign out_ch.data.tip_a_hits_elbow_b = hit_reg[1];
    assign out_ch.data.tip_a_hits_tip_b   = hit_reg[2];

    // checks
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(hit_reg))
        else $error("result changed under stall");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_ch.valid |-> in_ch.ready)
        else $error("input blocked with empty output");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        en |=> vld_reg[0] == $past(in_ch.valid))
        else $error("valid bit lost at entry");
endmodule
`default_nettype wire
